// ===== design/contiguous_page_frame_allocator_assert.svh =====
// assertion macros for the page frame allocator checkers
// the enclosing scope provides clk and arst_n
`ifndef CONTIGUOUS_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// consequent in the same cycle
`define CPFA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpfa: port check failed");

// consequent in the next cycle
`define CPFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpfa: port check failed");

`endif

// ===== design/cpfa_pkg.sv =====
package cpfa_pkg;

	localparam int BITMAP_WORDS = 1024;
	localparam int WORD_BITS    = 32;
	localparam int BIT_AW       = 5;
	localparam int WORD_AW      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int FRAME_AW     = WORD_AW + BIT_AW;
	localparam int TOTAL_FRAMES = BITMAP_WORDS * WORD_BITS;
	localparam int RUN_W        = FRAME_AW + 1;
	localparam int COUNT_W      = 16;
	localparam int CMP_W        = ((RUN_W > COUNT_W) ? RUN_W : COUNT_W) + 1;
	localparam int ADDR_W       = 32;
	localparam int FRAME_SHIFT  = 12;
	localparam int OFF_W        = ADDR_W - FRAME_SHIFT;
	localparam int CHK_W        = OFF_W + 1;
	localparam int LEVELS       = BIT_AW + 1;

	localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOMEM = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FCHK,
		S_PREP,
		S_MRD,
		S_MWR
	} state_t;

	// bit range of one word to set or clear
	typedef struct packed {
		logic              op;
		logic [BIT_AW-1:0] lo_bit;
		logic [BIT_AW-1:0] hi_bit;
	} mark_ctl_t;

	// outcome of evaluating one bitmap word during the scan
	typedef struct packed {
		logic              found;
		logic              from_carry;
		logic [BIT_AW-1:0] pos;
		logic [RUN_W-1:0]  next_run;
	} scan_res_t;

endpackage

// ===== design/cpfa_ram.sv =====
module cpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/cpfa_word_unit.sv =====
module cpfa_word_unit (
	input  logic [cpfa_pkg::WORD_BITS-1:0] word,
	input  logic [cpfa_pkg::RUN_W-1:0]     run,
	input  logic [cpfa_pkg::COUNT_W-1:0]   count,
	input  cpfa_pkg::mark_ctl_t            mark,
	output cpfa_pkg::scan_res_t            res,
	output logic [cpfa_pkg::WORD_BITS-1:0] new_word
);

	logic [cpfa_pkg::WORD_BITS-1:0]                        free_bits;
	logic [cpfa_pkg::LEVELS-1:0][cpfa_pkg::WORD_BITS-1:0]  runs;
	logic [cpfa_pkg::WORD_BITS-1:0]                        starts;
	logic [cpfa_pkg::BIT_AW:0]                             sh;
	logic [cpfa_pkg::BIT_AW:0]                             tz;
	logic [cpfa_pkg::BIT_AW:0]                             lz;
	logic [cpfa_pkg::BIT_AW-1:0]                           pos;
	logic [cpfa_pkg::CMP_W-1:0]                            sum;
	logic                                                  small_count;
	logic                                                  hit_carry;
	logic [cpfa_pkg::WORD_BITS-1:0]                        mask;

	always_comb begin
		free_bits = ~word;

		// free bits from the bottom and from the top
		tz = (cpfa_pkg::BIT_AW + 1)'(cpfa_pkg::WORD_BITS);
		for (int i = cpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (word[i]) begin
				tz = (cpfa_pkg::BIT_AW + 1)'(i);
			end
		end
		lz = (cpfa_pkg::BIT_AW + 1)'(cpfa_pkg::WORD_BITS);
		for (int i = 0; i < cpfa_pkg::WORD_BITS; i++) begin
			if (word[i]) begin
				lz = (cpfa_pkg::BIT_AW + 1)'(cpfa_pkg::WORD_BITS - 1 - i);
			end
		end

		// runs[k] marks positions that start 2**k free bits
		runs[0] = free_bits;
		for (int k = 1; k < cpfa_pkg::LEVELS; k++) begin
			runs[k] = runs[k-1] & (runs[k-1] >> (1 << (k - 1)));
		end

		// combine power-of-two runs into a run of exactly count bits
		starts = cpfa_pkg::WORD_ONES;
		sh     = '0;
		for (int b = 0; b < cpfa_pkg::LEVELS; b++) begin
			if (count[b]) begin
				starts = starts & (runs[b] >> sh);
				sh     = sh + (cpfa_pkg::BIT_AW + 1)'(1 << b);
			end
		end

		pos = '0;
		for (int i = cpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (starts[i]) begin
				pos = cpfa_pkg::BIT_AW'(i);
			end
		end

		small_count = count <= cpfa_pkg::COUNT_W'(cpfa_pkg::WORD_BITS);
		sum         = cpfa_pkg::CMP_W'(run) + cpfa_pkg::CMP_W'(tz);
		hit_carry   = sum >= cpfa_pkg::CMP_W'(count);

		res.found      = hit_carry || (small_count && (starts != '0));
		res.from_carry = hit_carry;
		res.pos        = pos;
		res.next_run   = (word == '0) ? run + cpfa_pkg::RUN_W'(cpfa_pkg::WORD_BITS)
		                              : cpfa_pkg::RUN_W'(lz);

		// read-modify-write of one word of a run
		mask = (cpfa_pkg::WORD_ONES << mark.lo_bit)
		     & (cpfa_pkg::WORD_ONES >> (cpfa_pkg::BIT_AW'(cpfa_pkg::WORD_BITS - 1) - mark.hi_bit));
		new_word = (mark.op == cpfa_pkg::OP_ALLOC) ? (word | mask) : (word & ~mask);
	end

endmodule

// ===== design/contiguous_page_frame_allocator.sv =====
// channel   direction  ports                                      handshake
// --------  ---------  -----------------------------------------  -------------------------
// request   in         operation, page_count, frame_address       start high, busy low
// result    out        address, status                            done high for one cycle
// config    in         base_address                               base_address_we high
//
// after reset a clearing pass writes every bitmap word to zero, with busy high
// zero count: the result follows in the next cycle, busy stays low
// allocate: a scan, then a read and a write for each word marked; the scan reads one bitmap word
//   a cycle through the shared word unit, up to BITMAP_WORDS words; no run: it ends after the last word
// free: a range check, then each word touched a read then a write; out of range: it ends after the check
// the result strobe cannot be stalled; busy drops in the cycle that the result is shown
module contiguous_page_frame_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             operation,
	input  logic [cpfa_pkg::COUNT_W-1:0]     page_count,
	input  logic [cpfa_pkg::ADDR_W-1:0]      frame_address,
	output logic                             done,
	output logic [cpfa_pkg::ADDR_W-1:0]      address,
	output logic [1:0]                       status,
	input  logic                             base_address_we,
	input  logic [cpfa_pkg::ADDR_W-1:0]      base_address
);

	localparam logic [cpfa_pkg::WORD_AW-1:0] LAST_WORD =
		cpfa_pkg::WORD_AW'(cpfa_pkg::BITMAP_WORDS - 1);

	cpfa_pkg::state_t state_q, state_d;

	// control
	logic [cpfa_pkg::WORD_AW-1:0]  clr_q;
	logic [cpfa_pkg::WORD_AW:0]    rd_w_q;
	logic                          rv_q;
	logic                          done_q;
	logic [cpfa_pkg::ADDR_W-1:0]   base_q;

	// item payload and scan state
	logic                          op_q;
	logic [cpfa_pkg::COUNT_W-1:0]  cnt_q;
	logic [cpfa_pkg::OFF_W-1:0]    off_q;
	logic [cpfa_pkg::WORD_AW-1:0]  ev_w_q;
	logic [cpfa_pkg::RUN_W-1:0]    run_q;
	logic [cpfa_pkg::FRAME_AW-1:0] lo_q;
	logic [cpfa_pkg::FRAME_AW-1:0] hi_q;
	logic [cpfa_pkg::WORD_AW-1:0]  w_q;
	logic [cpfa_pkg::ADDR_W-1:0]   address_q;
	logic [1:0]                    status_q;

	// bitmap port
	logic                           ram_we;
	logic [cpfa_pkg::WORD_AW-1:0]   ram_waddr;
	logic [cpfa_pkg::WORD_BITS-1:0] ram_wdata;
	logic [cpfa_pkg::WORD_AW-1:0]   ram_raddr;
	logic [cpfa_pkg::WORD_BITS-1:0] ram_rdata;

	cpfa_pkg::mark_ctl_t            mark;
	cpfa_pkg::scan_res_t            res;
	logic [cpfa_pkg::WORD_BITS-1:0] new_word;

	logic                           accept;
	logic                           issuing;
	logic                           last_ev;
	logic                           last_mark;
	logic                           out_range;
	logic [cpfa_pkg::ADDR_W-1:0]    diff;
	logic [cpfa_pkg::CHK_W-1:0]     end_frame;
	logic [cpfa_pkg::FRAME_AW-1:0]  found_frame;

	assign busy    = (state_q != cpfa_pkg::S_IDLE);
	assign accept  = start && !busy;
	assign done    = done_q;
	assign address = address_q;
	assign status  = status_q;

	// scan read pointer runs one word ahead of the word being evaluated
	assign issuing = rd_w_q < (cpfa_pkg::WORD_AW + 1)'(cpfa_pkg::BITMAP_WORDS);
	assign last_ev = (ev_w_q == LAST_WORD);

	// offset of the first frame to free, low 12 bits dropped
	assign diff      = frame_address - base_q;
	assign end_frame = cpfa_pkg::CHK_W'(off_q) + cpfa_pkg::CHK_W'(cnt_q);
	assign out_range = end_frame > cpfa_pkg::CHK_W'(cpfa_pkg::TOTAL_FRAMES);

	// run found either continues the carried run or sits inside this word
	assign found_frame = res.from_carry
		? cpfa_pkg::FRAME_AW'({1'b0, ev_w_q, {cpfa_pkg::BIT_AW{1'b0}}} - run_q)
		: {ev_w_q, res.pos};

	// bit range of the current word within the run lo_q .. hi_q
	assign last_mark   = (w_q == hi_q[cpfa_pkg::FRAME_AW-1:cpfa_pkg::BIT_AW]);
	assign mark.op     = op_q;
	assign mark.lo_bit = (w_q == lo_q[cpfa_pkg::FRAME_AW-1:cpfa_pkg::BIT_AW])
		? lo_q[cpfa_pkg::BIT_AW-1:0] : '0;
	assign mark.hi_bit = last_mark
		? hi_q[cpfa_pkg::BIT_AW-1:0] : cpfa_pkg::BIT_AW'(cpfa_pkg::WORD_BITS - 1);

	cpfa_ram #(
		.WIDTH (cpfa_pkg::WORD_BITS),
		.DEPTH (cpfa_pkg::BITMAP_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cpfa_word_unit u_word (
		.word     (ram_rdata),
		.run      (run_q),
		.count    (cnt_q),
		.mark     (mark),
		.res      (res),
		.new_word (new_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpfa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and bitmap port
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = new_word;
		ram_raddr = w_q;
		unique case (state_q)
			cpfa_pkg::S_CLEAR: begin
				// clearing pass, one word a cycle
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == LAST_WORD) begin
					state_d = cpfa_pkg::S_IDLE;
				end
			end
			cpfa_pkg::S_IDLE: begin
				if (accept && (page_count != '0)) begin
					state_d = (operation == cpfa_pkg::OP_FREE) ? cpfa_pkg::S_FCHK
					                                           : cpfa_pkg::S_SCAN;
				end
			end
			cpfa_pkg::S_SCAN: begin
				ram_raddr = rd_w_q[cpfa_pkg::WORD_AW-1:0];
				if (rv_q) begin
					if (res.found) begin
						state_d = cpfa_pkg::S_PREP;
					end else if (last_ev) begin
						state_d = cpfa_pkg::S_IDLE;
					end
				end
			end
			cpfa_pkg::S_FCHK: begin
				state_d = out_range ? cpfa_pkg::S_IDLE : cpfa_pkg::S_PREP;
			end
			cpfa_pkg::S_PREP: begin
				state_d = cpfa_pkg::S_MRD;
			end
			cpfa_pkg::S_MRD: begin
				state_d = cpfa_pkg::S_MWR;
			end
			cpfa_pkg::S_MWR: begin
				// read data of w_q is on the port now
				ram_we  = 1'b1;
				state_d = last_mark ? cpfa_pkg::S_IDLE : cpfa_pkg::S_MRD;
			end
			default: begin
				state_d = cpfa_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			rd_w_q <= '0;
			rv_q   <= 1'b0;
			done_q <= 1'b0;
			base_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (base_address_we) begin
				base_q <= base_address;
			end
			case (state_q)
				cpfa_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				cpfa_pkg::S_IDLE: begin
					rd_w_q <= '0;
					rv_q   <= 1'b0;
					if (accept && (page_count == '0)) begin
						done_q <= 1'b1;
					end
				end
				cpfa_pkg::S_SCAN: begin
					rv_q <= issuing;
					if (issuing) begin
						rd_w_q <= rd_w_q + 1'b1;
					end
					if (rv_q && !res.found && last_ev) begin
						done_q <= 1'b1;
					end
				end
				cpfa_pkg::S_FCHK: begin
					if (out_range) begin
						done_q <= 1'b1;
					end
				end
				cpfa_pkg::S_MWR: begin
					if (last_mark) begin
						done_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload and scan state
	always_ff @(posedge clk) begin
		case (state_q)
			cpfa_pkg::S_IDLE: begin
				if (accept) begin
					op_q      <= operation;
					cnt_q     <= page_count;
					off_q     <= diff[cpfa_pkg::ADDR_W-1:cpfa_pkg::FRAME_SHIFT];
					run_q     <= '0;
					address_q <= '0;
					status_q  <= cpfa_pkg::ST_ZERO;
				end
			end
			cpfa_pkg::S_SCAN: begin
				ev_w_q <= rd_w_q[cpfa_pkg::WORD_AW-1:0];
				if (rv_q) begin
					if (res.found) begin
						lo_q <= found_frame;
					end else begin
						run_q <= res.next_run;
						if (last_ev) begin
							address_q <= '0;
							status_q  <= cpfa_pkg::ST_NOMEM;
						end
					end
				end
			end
			cpfa_pkg::S_FCHK: begin
				if (out_range) begin
					address_q <= '0;
					status_q  <= cpfa_pkg::ST_RANGE;
				end else begin
					lo_q <= off_q[cpfa_pkg::FRAME_AW-1:0];
				end
			end
			cpfa_pkg::S_PREP: begin
				// last frame of the run, modulo the frame count
				hi_q <= cpfa_pkg::FRAME_AW'(lo_q + cpfa_pkg::FRAME_AW'(cnt_q) - 1'b1);
				w_q  <= lo_q[cpfa_pkg::FRAME_AW-1:cpfa_pkg::BIT_AW];
				address_q <= (op_q == cpfa_pkg::OP_ALLOC)
					? base_q + cpfa_pkg::ADDR_W'({lo_q, {cpfa_pkg::FRAME_SHIFT{1'b0}}})
					: '0;
				status_q <= cpfa_pkg::ST_OK;
			end
			cpfa_pkg::S_MWR: begin
				w_q <= w_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/cpfa_checker.sv =====
`include "contiguous_page_frame_allocator_assert.svh"

module cpfa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [cpfa_pkg::COUNT_W-1:0]   page_count,
	input logic                           done,
	input logic [cpfa_pkg::ADDR_W-1:0]    address,
	input logic [1:0]                     status
);

	// a real request makes the block busy in the next cycle
	`CPFA_ASSERT_NEXT(a_busy_after_req, start && !busy && page_count != '0, busy)

	// failures and zero-count results answer address zero
	`CPFA_ASSERT_SAME(a_addr_zero, done && status != cpfa_pkg::ST_OK, address == '0)

	// zero-count status only straight after a zero-count request
	`CPFA_ASSERT_SAME(a_zero_src, done && status == cpfa_pkg::ST_ZERO,
		$past(start && !busy && page_count == '0))

	// every other result comes out of a busy period
	`CPFA_ASSERT_SAME(a_work_src, done && status != cpfa_pkg::ST_ZERO, $past(busy))

endmodule

bind contiguous_page_frame_allocator cpfa_checker u_cpfa_checker (.*);

// ===== test/contiguous_page_frame_allocator_tb.sv =====
`timescale 1ns / 1ps

module contiguous_page_frame_allocator_tb;
	import cpfa_pkg::*;

	// one answer as the block shows it on its result ports
	typedef struct {
		logic [ADDR_W-1:0] address;
		logic [1:0]        status;
	} answer_t;

	// a run of frames the stimulus believes it owns, kept so it can hand them back
	typedef struct {
		int unsigned frame;
		int unsigned count;
	} holding_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                operation;
	logic [COUNT_W-1:0]  page_count;
	logic [ADDR_W-1:0]   frame_address;
	logic                done;
	logic [ADDR_W-1:0]   address;
	logic [1:0]          status;
	logic                base_address_we;
	logic [ADDR_W-1:0]   base_address;

	// our own copy of the frame bitmap and of the base register
	bit [WORD_BITS-1:0]  frame_map [BITMAP_WORDS];
	logic [ADDR_W-1:0]   model_base = '0;
	int unsigned         last_alloc_frame;

	answer_t             answers_due[$];
	holding_t            holdings[$];
	int unsigned         frames_held = 0;
	int                  mismatch_count = 0;
	int                  idle_pct = 0;

	contiguous_page_frame_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.page_count      (page_count),
		.frame_address   (frame_address),
		.done            (done),
		.address         (address),
		.status          (status),
		.base_address_we (base_address_we),
		.base_address    (base_address)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, several times the slowest legal run including the clearing pass
	initial begin
		#80_000_000;
		$display("contiguous_page_frame_allocator_tb failed");
		$finish;
	end

	// physical address of a frame under the current base, wrapping like the block
	function automatic logic [ADDR_W-1:0] frame_addr(int unsigned f);
		return model_base + (ADDR_W'(f) << FRAME_SHIFT);
	endfunction

	// works out the answer to one item and updates the bitmap copy
	function automatic answer_t predict_answer(logic op, logic [COUNT_W-1:0] cnt,
			logic [ADDR_W-1:0] faddr);
		answer_t           ans;
		int unsigned       run;
		int unsigned       first;
		int unsigned       p;
		int unsigned       k;
		int unsigned       offset;
		logic [ADDR_W-1:0] diff;
		bit                found;
		ans.address = '0;
		if (cnt == 0) begin
			// zero count, for either operation: nothing changes
			ans.status = ST_ZERO;
		end else if (op == OP_ALLOC) begin
			// first-fit from frame 0, the run may cross word boundaries
			ans.status = ST_NOMEM;
			run = 0;
			first = 0;
			p = 0;
			found = 1'b0;
			while (p < TOTAL_FRAMES && !found) begin
				if (frame_map[p / WORD_BITS] == WORD_ONES) begin
					// whole word used, jump to the next one
					run = 0;
					p = (p | (WORD_BITS - 1)) + 1;
				end else if (frame_map[p / WORD_BITS][p % WORD_BITS]) begin
					run = 0;
					p++;
				end else begin
					if (run == 0)
						first = p;
					run++;
					if (run == cnt)
						found = 1'b1;
					else
						p++;
				end
			end
			if (found) begin
				for (k = first; k <= p; k++)
					frame_map[k / WORD_BITS][k % WORD_BITS] = 1'b1;
				ans.address = frame_addr(first);
				ans.status = ST_OK;
				last_alloc_frame = first;
			end
		end else begin
			// offset wraps below the base, the low twelve bits are dropped
			diff = faddr - model_base;
			offset = diff >> FRAME_SHIFT;
			if (offset + cnt > TOTAL_FRAMES) begin
				ans.status = ST_RANGE;
			end else begin
				for (k = offset; k < offset + cnt; k++)
					frame_map[k / WORD_BITS][k % WORD_BITS] = 1'b0;
				ans.status = ST_OK;
			end
		end
		return ans;
	endfunction

	function void report(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
	endfunction

	// result side: every strobe is matched against the oldest outstanding answer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				report("result with nothing outstanding", '0, address);
			end else begin
				want = answers_due.pop_front();
				if (address !== want.address)
					report("address", want.address, address);
				if (status !== want.status)
					report("status", ADDR_W'(want.status), ADDR_W'(status));
			end
		end
	end

	// idle length before the next item: geometric, with the odd long pause
	function automatic int pick_gap();
		int g;
		g = 0;
		if (idle_pct > 0) begin
			while ($urandom_range(99) < idle_pct && g < 40)
				g++;
			if ($urandom_range(9) == 0)
				g += $urandom_range(150);
		end
		return g;
	endfunction

	// presents one item from a falling edge, holds it until accepted, returns at
	// the next falling edge with start still high so items can follow back to back
	task automatic send_item(logic op, logic [COUNT_W-1:0] cnt, logic [ADDR_W-1:0] faddr,
			int gap);
		answer_t ans;
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = op;
		page_count = cnt;
		frame_address = faddr;
		start = 1'b1;
		do @(posedge clk); while (busy);
		ans = predict_answer(op, cnt, faddr);
		answers_due.push_back(ans);
		if (op == OP_ALLOC && cnt != 0 && ans.status == ST_OK) begin
			holdings.push_back('{last_alloc_frame, cnt});
			frames_held += cnt;
		end
		@(negedge clk);
	endtask

	// lowers start and waits, from a falling edge, until every answer has come
	task automatic wait_idle();
		start = 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// only ever called with the block idle
	task automatic set_base(logic [ADDR_W-1:0] value);
		start = 1'b0;
		base_address = value;
		base_address_we = 1'b1;
		@(negedge clk);
		base_address_we = 1'b0;
		model_base = value;
	endtask

	// extremes of each field, both operations and every special case
	task automatic test_directed();
		set_base(32'hFC00_0000);
		// zero count on both operations
		send_item(OP_ALLOC, 0, $urandom, 0);
		send_item(OP_FREE, 0, $urandom, 0);
		// fill word 0, then a run that crosses into word 2
		send_item(OP_ALLOC, 1, $urandom, 0);
		send_item(OP_ALLOC, 31, $urandom, 0);
		send_item(OP_ALLOC, 40, $urandom, 0);
		// free frame 0 with the low address bits set, first fit must find it again
		send_item(OP_FREE, 1, frame_addr(0) | 32'h0000_0FFF, 0);
		send_item(OP_ALLOC, 1, $urandom, 0);
		// freeing frames that are already free
		send_item(OP_FREE, 3, frame_addr(5000), 0);
		// last frame: one past is out of range, exactly to the end is fine
		send_item(OP_FREE, 2, frame_addr(TOTAL_FRAMES - 1), 0);
		send_item(OP_FREE, 1, frame_addr(TOTAL_FRAMES - 1), 0);
		// address below the base wraps to a huge offset
		send_item(OP_FREE, 1, model_base - 32'h0000_1000, 0);
		// no run long enough, and a count beyond the whole store
		send_item(OP_ALLOC, TOTAL_FRAMES, $urandom, 0);
		send_item(OP_ALLOC, 16'hFFFF, $urandom, 0);
		send_item(OP_FREE, 16'hFFFF, frame_addr(0), 0);
		// clear everything, take the whole store, then nothing is left
		send_item(OP_FREE, TOTAL_FRAMES, frame_addr(0), 0);
		send_item(OP_ALLOC, TOTAL_FRAMES, $urandom, 0);
		send_item(OP_ALLOC, 1, $urandom, 0);
		// the top frame alone: its address wraps past 2^32 under this base
		send_item(OP_FREE, 1, frame_addr(TOTAL_FRAMES - 1), 0);
		send_item(OP_ALLOC, 1, $urandom, 0);
		send_item(OP_FREE, TOTAL_FRAMES, frame_addr(0), 0);
		wait_idle();
		holdings.delete();
		frames_held = 0;
	endtask

	// mostly allocate and give back what was taken, with noise mixed in
	task automatic test_random(int items, int pct, logic [ADDR_W-1:0] base, bit pause_once);
		int          choice;
		int          idx;
		int unsigned k;
		holding_t    h;
		wait_idle();
		set_base(base);
		idle_pct = pct;
		for (int i = 0; i < items; i++) begin
			// sender holds off until every answer is home
			if ((pause_once && i == items / 2) || $urandom_range(49) == 0)
				wait_idle();
			choice = $urandom_range(99);
			// keep the store lightly used so scans stay short
			if (frames_held > 2500 && choice < 42)
				choice = 50;
			if (choice >= 42 && choice < 72 && holdings.size() == 0)
				choice = 0;
			if (choice < 42) begin
				k = ($urandom_range(3) == 0) ? $urandom_range(300, 1) : $urandom_range(40, 1);
				send_item(OP_ALLOC, k, $urandom, pick_gap());
			end else if (choice < 72) begin
				// hand back a held run, whole or a leading part
				idx = $urandom_range(holdings.size() - 1);
				h = holdings[idx];
				k = ($urandom_range(3) == 0) ? $urandom_range(h.count, 1) : h.count;
				send_item(OP_FREE, k, frame_addr(h.frame) + $urandom_range(4095), pick_gap());
				if (k == h.count) begin
					holdings.delete(idx);
				end else begin
					holdings[idx].frame = h.frame + k;
					holdings[idx].count = h.count - k;
				end
				frames_held -= k;
			end else if (choice < 79) begin
				send_item($urandom_range(1), 0, $urandom, pick_gap());
			end else if (choice < 86) begin
				send_item(OP_FREE, $urandom_range(65535), $urandom, pick_gap());
			end else if (choice < 91) begin
				// around the top of the store, some fit and some reach past it
				send_item(OP_FREE, $urandom_range(12, 1),
					frame_addr(TOTAL_FRAMES - $urandom_range(8, 1)) + $urandom_range(4095),
					pick_gap());
			end else if (choice < 95) begin
				// free wherever, often frames that are free already
				send_item(OP_FREE, $urandom_range(64, 1),
					frame_addr($urandom_range(TOTAL_FRAMES - 1)), pick_gap());
			end else begin
				send_item(OP_ALLOC, $urandom_range(65535, 1), $urandom, pick_gap());
			end
		end
		wait_idle();
	endtask

	initial begin
		start = 1'b0;
		operation = OP_ALLOC;
		page_count = '0;
		frame_address = '0;
		base_address_we = 1'b0;
		base_address = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		// clearing pass after reset keeps busy high
		do @(posedge clk); while (busy);
		@(negedge clk);

		test_directed();
		test_random(140, 0, 32'h0000_0000, 1'b0);
		test_random(140, 63, 32'hFFFF_FFFF, 1'b0);
		test_random(140, 0, $urandom, 1'b1);
		test_random(140, 36, $urandom, 1'b0);

		// room for a stray strobe after the last answer
		wait_idle();
		repeat (3200) @(posedge clk);
		if (mismatch_count == 0)
			$display("contiguous_page_frame_allocator_tb passed");
		else
			$display("contiguous_page_frame_allocator_tb failed");
		$finish;
	end

endmodule
